/* rtl/lcvs_pkg.sv */
package lcvs_pkg;

    // Field widths fixed by the item formats
    localparam int MODE_W  = 2;
    localparam int COORD_W = 4;
    localparam int BYTE_W  = 8;
    localparam int DWELL_W = 16;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd100;

    // Item mode codes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic ready;   // free to take an input transaction
        logic accept;  // input transaction taken this cycle
        logic fetch;   // read the store into the read register
        logic clear;   // drop every stored byte
        logic write;   // write the merged byte back
        logic emit;    // load the result register and step the scan
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              in_range;
        logic              out_free;
    } stat_t;

endpackage

/* rtl/lcvs_if.sv */
interface lcvs_item_if;
    logic                            valid;
    logic                            ready;
    logic [lcvs_pkg::MODE_W-1:0]     mode;
    logic [lcvs_pkg::COORD_W-1:0]    voxel_x;
    logic [lcvs_pkg::COORD_W-1:0]    voxel_y;
    logic [lcvs_pkg::COORD_W-1:0]    voxel_z;
    logic                            voxel_on;

    modport source (output valid, mode, voxel_x, voxel_y, voxel_z, voxel_on, input ready);
    modport sink   (input valid, mode, voxel_x, voxel_y, voxel_z, voxel_on, output ready);
endinterface

interface lcvs_result_if;
    logic                         valid;
    logic                         ready;
    logic [lcvs_pkg::BYTE_W-1:0]  column_enable;
    logic [lcvs_pkg::BYTE_W-1:0]  row_lines;
    logic                         layer_clock;
    logic                         layer_serial;

    modport source (output valid, column_enable, row_lines, layer_clock, layer_serial,
                    input ready);
    modport sink   (input valid, column_enable, row_lines, layer_clock, layer_serial,
                    output ready);
endinterface

/* rtl/led_cube_voxel_scan_driver.sv */
// Channel   Dir  Transaction            Payload
// item      in   scan tick/write/clear  mode, voxel_x, voxel_y, voxel_z, voxel_on
// result    out  pin levels per tick    column_enable, row_lines, layer_clock, layer_serial
// cfg       in   dwell_ticks write      cfg_write, cfg_data
//
// Scan ticks and in-range writes pass through accept, store fetch, then result load or
// write-back; the registered store read behind the controller adds the fetch step.
// Clear, unused-mode and out-of-range write items end after the fetch step; a stalled result
// holds a scan tick in the result-load step until the result register empties.
// Reset is asynchronous; the store reads as zero straight after reset through per-entry
// valid bits, so there is no clearing pass.
module led_cube_voxel_scan_driver
#(
    parameter int LAYER_COUNT  = 8,
    parameter int COLUMN_COUNT = 8,
    parameter int ROW_COUNT    = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    lcvs_item_if.sink                     item,
    lcvs_result_if.source                 result,
    input  logic                          cfg_write,
    input  logic [lcvs_pkg::DWELL_W-1:0]  cfg_data
);

    lcvs_pkg::cmd_t  cmd;
    lcvs_pkg::stat_t stat;

    assign item.ready = cmd.ready;

    lcvs_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .stat       (stat),
        .cmd        (cmd)
    );

    lcvs_datapath
    #(
        .LAYER_COUNT  (LAYER_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT),
        .ROW_COUNT    (ROW_COUNT)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .mode          (item.mode),
        .voxel_x       (item.voxel_x),
        .voxel_y       (item.voxel_y),
        .voxel_z       (item.voxel_z),
        .voxel_on      (item.voxel_on),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .column_enable (result.column_enable),
        .row_lines     (result.row_lines),
        .layer_clock   (result.layer_clock),
        .layer_serial  (result.layer_serial)
    );

endmodule

/* rtl/lcvs_ctrl.sv */
module lcvs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  lcvs_pkg::stat_t stat,
    output lcvs_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WRITE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands from the current state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = item_valid;
                if (item_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                cmd.clear = (stat.mode == lcvs_pkg::MODE_CLEAR);
                if (stat.mode == lcvs_pkg::MODE_TICK)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.mode == lcvs_pkg::MODE_WRITE && stat.in_range)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                // hold until the result register is free
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fetch, cmd.write, cmd.emit}))
        else $error("more than one datapath action at once");

    a_accept_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.fetch)
        else $error("accepted transaction not fetched");

    a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !stat.out_free) |=> state_reg == ST_EMIT)
        else $error("result dropped while output stalled");

endmodule

/* rtl/lcvs_datapath.sv */
module lcvs_datapath
#(
    parameter int LAYER_COUNT  = 8,
    parameter int COLUMN_COUNT = 8,
    parameter int ROW_COUNT    = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcvs_pkg::cmd_t                cmd,
    output lcvs_pkg::stat_t               stat,
    input  logic                          cfg_write,
    input  logic [lcvs_pkg::DWELL_W-1:0]  cfg_data,
    input  logic [lcvs_pkg::MODE_W-1:0]   mode,
    input  logic [lcvs_pkg::COORD_W-1:0]  voxel_x,
    input  logic [lcvs_pkg::COORD_W-1:0]  voxel_y,
    input  logic [lcvs_pkg::COORD_W-1:0]  voxel_z,
    input  logic                          voxel_on,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [lcvs_pkg::BYTE_W-1:0]   column_enable,
    output logic [lcvs_pkg::BYTE_W-1:0]   row_lines,
    output logic                          layer_clock,
    output logic                          layer_serial
);

    localparam int DEPTH   = LAYER_COUNT * COLUMN_COUNT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAYER_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
    localparam int COL_W   = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int BW      = lcvs_pkg::BYTE_W;
    localparam int DW      = lcvs_pkg::DWELL_W;

    localparam logic [BW-1:0]      DRIVEN_ROWS = BW'((1 << ROW_COUNT) - 1);
    localparam logic [BW-1:0]      UNDRIVEN    = ~DRIVEN_ROWS;
    localparam logic [LAYER_W-1:0] LAST_LAYER  = LAYER_W'(LAYER_COUNT - 1);
    localparam logic [COL_W-1:0]   LAST_COL    = COL_W'(COLUMN_COUNT - 1);

    typedef enum logic [1:0] {
        PH_FRAME,
        PH_LIT,
        PH_BLANK,
        PH_LAYER
    } phase_t;

    // Item and configuration registers
    logic [lcvs_pkg::MODE_W-1:0]  mode_reg;
    logic [lcvs_pkg::COORD_W-1:0] x_reg;
    logic [lcvs_pkg::COORD_W-1:0] y_reg;
    logic [lcvs_pkg::COORD_W-1:0] z_reg;
    logic                         on_reg;
    logic [DW-1:0]                dwell_reg;

    // Store
    logic [BW-1:0]     mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [BW-1:0]     rd_data_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [BW-1:0]     stored;
    logic [BW-1:0]     bit_mask;
    logic [BW-1:0]     merged;
    logic              in_range;

    // Scan state
    phase_t            phase_reg, phase_next;
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [DW-1:0]     cnt_reg, cnt_next;
    logic [DW:0]       dwell_eff;

    // Result register
    logic              out_valid_reg;
    logic [BW-1:0]     col_en_reg, col_en_next;
    logic [BW-1:0]     rows_reg, rows_next;
    logic              lclk_reg, lclk_next;
    logic              ldat_reg, ldat_next;

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            x_reg    <= voxel_x;
            y_reg    <= voxel_y;
            z_reg    <= voxel_z;
            on_reg   <= voxel_on;
        end
    end

    // Hold the dwell register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= lcvs_pkg::DWELL_RESET;
        end
        else if (cfg_write)
        begin
            dwell_reg <= cfg_data;
        end
    end

    assign in_range = (int'(x_reg) < COLUMN_COUNT) && (int'(y_reg) < ROW_COUNT)
                   && (int'(z_reg) < LAYER_COUNT);

    assign stat.mode     = mode_reg;
    assign stat.in_range = in_range;
    assign stat.out_free = !out_valid_reg || out_ready;

    // Pick the write target or the scan position
    always_comb
    begin
        if (mode_reg == lcvs_pkg::MODE_WRITE && in_range)
        begin
            rd_addr = ADDR_W'(int'(z_reg) * COLUMN_COUNT + int'(x_reg));
        end
        else
        begin
            rd_addr = ADDR_W'(int'(layer_reg) * COLUMN_COUNT + int'(col_reg));
        end
    end

    // Read and write the store
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            addr_reg     <= rd_addr;
        end
        if (cmd.write)
        begin
            mem[addr_reg] <= merged;
        end
    end

    // Track written entries; drop them all on a clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    // Merge the voxel bit into the stored byte
    assign stored   = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask = BW'(1) << y_reg[2:0];
    assign merged   = on_reg ? (stored | bit_mask) : (stored & ~bit_mask);

    assign dwell_eff = (dwell_reg == '0) ? (DW+1)'(1) : {1'b0, dwell_reg};

    // Work out the pin levels and the next scan position
    always_comb
    begin
        phase_next  = phase_reg;
        layer_next  = layer_reg;
        col_next    = col_reg;
        cnt_next    = cnt_reg;
        col_en_next = '0;
        rows_next   = '1;
        lclk_next   = 1'b0;
        ldat_next   = 1'b0;
        unique case (phase_reg)
            PH_FRAME:
            begin
                lclk_next  = 1'b1;
                ldat_next  = 1'b1;
                layer_next = '0;
                col_next   = '0;
                cnt_next   = '0;
                phase_next = PH_LIT;
            end
            PH_LIT:
            begin
                col_en_next = (int'(col_reg) < BW) ? (BW'(1) << col_reg) : '0;
                rows_next   = ~stored | UNDRIVEN;
                if (({1'b0, cnt_reg} + (DW+1)'(1)) >= dwell_eff)
                begin
                    cnt_next   = '0;
                    phase_next = PH_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + DW'(1);
                end
            end
            PH_BLANK:
            begin
                if (col_reg == LAST_COL)
                begin
                    col_next   = '0;
                    phase_next = PH_LAYER;
                end
                else
                begin
                    col_next   = col_reg + COL_W'(1);
                    phase_next = PH_LIT;
                end
            end
            PH_LAYER:
            begin
                lclk_next = 1'b1;
                if (layer_reg == LAST_LAYER)
                begin
                    layer_next = '0;
                    phase_next = PH_FRAME;
                end
                else
                begin
                    layer_next = layer_reg + LAYER_W'(1);
                    phase_next = PH_LIT;
                end
            end
            default:
            begin
                phase_next = PH_FRAME;
            end
        endcase
    end

    // Advance the scan and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FRAME;
            layer_reg     <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                phase_reg     <= phase_next;
                layer_reg     <= layer_next;
                col_reg       <= col_next;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            col_en_reg <= col_en_next;
            rows_reg   <= rows_next;
            lclk_reg   <= lclk_next;
            ldat_reg   <= ldat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign column_enable = col_en_reg;
    assign row_lines     = rows_reg;
    assign layer_clock   = lclk_reg;
    assign layer_serial  = ldat_reg;

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not presented");

    a_frame_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ldat_reg) |-> (lclk_reg && col_en_reg == '0))
        else $error("frame start tick with wrong pin levels");

    a_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (mode_reg == lcvs_pkg::MODE_WRITE && in_range))
        else $error("store written by an illegal item");

endmodule

/* bench/tb_led_cube_voxel_scan_driver.sv */
`timescale 1ns / 100ps

module tb_led_cube_voxel_scan_driver;

    localparam int LAYERS        = 8;
    localparam int COLUMNS       = 8;
    localparam int ROWS          = 8;
    localparam int CELLS         = LAYERS * COLUMNS;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;

    typedef logic [lcvs_pkg::MODE_W-1:0]  mode_t;
    typedef logic [lcvs_pkg::COORD_W-1:0] coord_t;
    typedef logic [lcvs_pkg::DWELL_W-1:0] dwell_t;

    // Mode code that the block must ignore
    localparam mode_t MODE_SPARE = 2'd3;

    typedef enum logic [1:0] {
        SCAN_FRAME,
        SCAN_LIT,
        SCAN_BLANK,
        SCAN_LAYER
    } scan_phase_t;

    typedef struct {
        mode_t  mode;
        coord_t x;
        coord_t y;
        coord_t z;
        logic   on;
    } voxel_cmd_t;

    typedef struct {
        logic [lcvs_pkg::BYTE_W-1:0] column_enable;
        logic [lcvs_pkg::BYTE_W-1:0] row_lines;
        logic                        layer_clock;
        logic                        layer_serial;
    } pin_levels_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_write;
    dwell_t cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // Scan predictor state
    logic [lcvs_pkg::BYTE_W-1:0] voxel_mem [CELLS];
    scan_phase_t                 phase_q;
    int unsigned                 layer_q;
    int unsigned                 column_q;
    int unsigned                 dwell_q;
    dwell_t                      dwell_ticks_q;
    pin_levels_t                 expected_pins [$];

    lcvs_item_if   item_ch ();
    lcvs_result_if result_ch ();

    led_cube_voxel_scan_driver
    #(
        .LAYER_COUNT  (LAYERS),
        .COLUMN_COUNT (COLUMNS),
        .ROW_COUNT    (ROWS)
    )
    DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one accepted transaction; a scan tick advances the scan and queues the pin levels it yields
    function automatic void scan_model(input voxel_cmd_t c);
        pin_levels_t p;
        int unsigned span;
        p.column_enable = '0;
        p.row_lines     = '1;
        p.layer_clock   = 1'b0;
        p.layer_serial  = 1'b0;
        if (c.mode == lcvs_pkg::MODE_WRITE)
        begin
            // Out-of-range coordinates leave the store untouched
            if (c.x < COLUMNS && c.y < ROWS && c.z < LAYERS)
                voxel_mem[c.z * COLUMNS + c.x][c.y] = c.on;
        end
        else if (c.mode == lcvs_pkg::MODE_CLEAR)
        begin
            foreach (voxel_mem[i])
                voxel_mem[i] = '0;
        end
        else if (c.mode == lcvs_pkg::MODE_TICK)
        begin
            case (phase_q)
                SCAN_FRAME:
                begin
                    p.layer_clock  = 1'b1;
                    p.layer_serial = 1'b1;
                    layer_q  = 0;
                    column_q = 0;
                    dwell_q  = 0;
                    phase_q  = SCAN_LIT;
                end
                SCAN_LIT:
                begin
                    // A zero dwell behaves as one tick
                    span = (dwell_ticks_q == '0) ? 1 : dwell_ticks_q;
                    p.column_enable = 8'd1 << column_q;
                    p.row_lines     = ~voxel_mem[layer_q * COLUMNS + column_q];
                    if (dwell_q + 1 >= span)
                    begin
                        dwell_q = 0;
                        phase_q = SCAN_BLANK;
                    end
                    else
                        dwell_q++;
                end
                SCAN_BLANK:
                begin
                    column_q++;
                    if (column_q >= COLUMNS)
                    begin
                        column_q = 0;
                        phase_q  = SCAN_LAYER;
                    end
                    else
                        phase_q = SCAN_LIT;
                end
                default:
                begin
                    p.layer_clock = 1'b1;
                    layer_q++;
                    if (layer_q >= LAYERS)
                    begin
                        layer_q = 0;
                        phase_q = SCAN_FRAME;
                    end
                    else
                        phase_q = SCAN_LIT;
                end
            endcase
            expected_pins.push_back(p);
        end
    endfunction

    function automatic voxel_cmd_t make_cmd(input mode_t mode,
                                            input coord_t x,
                                            input coord_t y,
                                            input coord_t z,
                                            input logic on);
        voxel_cmd_t c;
        c.mode = mode;
        c.x    = x;
        c.y    = y;
        c.z    = z;
        c.on   = on;
        return c;
    endfunction

    // Mostly scan ticks and in-range writes; some stray writes, spare modes and clears
    function automatic voxel_cmd_t random_cmd();
        voxel_cmd_t  c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        c = make_cmd(lcvs_pkg::MODE_TICK, coord_t'($urandom_range(0, 15)),
                     coord_t'($urandom_range(0, 15)), coord_t'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
        if (pick >= 99)
            c.mode = lcvs_pkg::MODE_CLEAR;
        else if (pick >= 95)
            c.mode = MODE_SPARE;
        else if (pick >= 90)
            c.mode = lcvs_pkg::MODE_WRITE;
        else if (pick >= 68)
        begin
            c.mode = lcvs_pkg::MODE_WRITE;
            c.x    = coord_t'($urandom_range(0, COLUMNS - 1));
            c.y    = coord_t'($urandom_range(0, ROWS - 1));
            c.z    = coord_t'($urandom_range(0, LAYERS - 1));
        end
        return c;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_cmd(input voxel_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.mode     <= c.mode;
        item_ch.voxel_x  <= c.x;
        item_ch.voxel_y  <= c.y;
        item_ch.voxel_z  <= c.z;
        item_ch.voxel_on <= c.on;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        scan_model(c);
    endtask

    // Drop valid, wait for every pending result, then let in-flight writes finish
    task automatic settle_channel();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dwell(input dwell_t value);
        settle_channel();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        dwell_ticks_q = value;
    endtask

    // Frame start, then the first lit ticks of an empty store at the reset dwell
    task automatic test_reset_scan();
        repeat (4)
            send_cmd(make_cmd(lcvs_pkg::MODE_TICK, coord_t'($urandom_range(0, 15)),
                              coord_t'($urandom_range(0, 15)),
                              coord_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    endtask

    // Writes seen through the lit column of layer zero
    task automatic test_voxel_writes();
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd0, 4'd0, 4'd0, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd0, 4'd7, 4'd0, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_TICK, 4'd0, 4'd0, 4'd0, 1'b0));
        // Out-of-range coordinates, and the far corner of the cube
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd15, 4'd1, 4'd0, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd0, 4'd15, 4'd0, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd0, 4'd1, 4'd15, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd8, 4'd1, 4'd0, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd7, 4'd7, 4'd7, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_TICK, 4'd15, 4'd15, 4'd15, 1'b1));
        // Spare mode must not write
        send_cmd(make_cmd(MODE_SPARE, 4'd0, 4'd1, 4'd0, 1'b1));
        send_cmd(make_cmd(lcvs_pkg::MODE_TICK, 4'd0, 4'd0, 4'd0, 1'b0));
        send_cmd(make_cmd(lcvs_pkg::MODE_WRITE, 4'd0, 4'd0, 4'd0, 1'b0));
        send_cmd(make_cmd(lcvs_pkg::MODE_TICK, 4'd0, 4'd0, 4'd0, 1'b0));
        send_cmd(make_cmd(lcvs_pkg::MODE_CLEAR, 4'd0, 4'd0, 4'd0, 1'b0));
        send_cmd(make_cmd(lcvs_pkg::MODE_TICK, 4'd0, 4'd0, 4'd0, 1'b0));
    endtask

    task automatic test_random_traffic(input int unsigned count,
                                       input dwell_t dwell,
                                       input bit hold_midway);
        set_dwell(dwell);
        for (int i = 0; i < count; i++)
        begin
            // Hold the sender off until the block has drained
            if (hold_midway && i == count / 2)
                settle_channel();
            send_cmd(random_cmd());
        end
    endtask

    // Random backpressure on the result channel
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_pins
        pin_levels_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_pins.size() == 0)
            begin
                $display("%0t: unexpected result col %h rows %h clk %b data %b", $time,
                         result_ch.column_enable, result_ch.row_lines,
                         result_ch.layer_clock, result_ch.layer_serial);
                mismatch_count++;
            end
            else
            begin
                want = expected_pins.pop_front();
                if (result_ch.column_enable !== want.column_enable)
                begin
                    $display("%0t: column_enable expected %h, got %h", $time,
                             want.column_enable, result_ch.column_enable);
                    mismatch_count++;
                end
                if (result_ch.row_lines !== want.row_lines)
                begin
                    $display("%0t: row_lines expected %h, got %h", $time,
                             want.row_lines, result_ch.row_lines);
                    mismatch_count++;
                end
                if (result_ch.layer_clock !== want.layer_clock)
                begin
                    $display("%0t: layer_clock expected %b, got %b", $time,
                             want.layer_clock, result_ch.layer_clock);
                    mismatch_count++;
                end
                if (result_ch.layer_serial !== want.layer_serial)
                begin
                    $display("%0t: layer_serial expected %b, got %b", $time,
                             want.layer_serial, result_ch.layer_serial);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_write        <= 1'b0;
        cfg_data         <= '0;
        item_ch.valid    <= 1'b0;
        item_ch.mode     <= lcvs_pkg::MODE_TICK;
        item_ch.voxel_x  <= '0;
        item_ch.voxel_y  <= '0;
        item_ch.voxel_z  <= '0;
        item_ch.voxel_on <= 1'b0;
        send_idle_pct  = 32;
        recv_idle_pct  = 76;

        // Predictor matches the block's reset state
        foreach (voxel_mem[i])
            voxel_mem[i] = '0;
        phase_q       = SCAN_FRAME;
        layer_q       = 0;
        column_q      = 0;
        dwell_q       = 0;
        dwell_ticks_q = lcvs_pkg::DWELL_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_scan();
        test_voxel_writes();
        test_random_traffic(340, 16'd0, 1'b1);

        send_idle_pct = 76;
        recv_idle_pct = 32;
        test_random_traffic(340, 16'd2, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(150, 16'd1, 1'b0);
        test_random_traffic(150, dwell_t'($urandom_range(3, 6)), 1'b0);
        test_random_traffic(30, 16'hFFFF, 1'b0);

        settle_channel();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* led_cube_voxel_scan_driver.f */
rtl/lcvs_pkg.sv
rtl/lcvs_if.sv
rtl/lcvs_ctrl.sv
rtl/lcvs_datapath.sv
rtl/led_cube_voxel_scan_driver.sv
bench/tb_led_cube_voxel_scan_driver.sv
